[rtl/core/isi_pkg.sv]
// Shared types, codes and constants for the independent-set signature index.
`timescale 1ns / 1ps
package isi_pkg;

  localparam int VERT_W  = 10;
  localparam int EDGE_W  = 2 * VERT_W;
  localparam int DEG_W   = 14;
  localparam int CNT_W   = 7;
  localparam int SIG_W   = 64;
  localparam int CFG_W   = 11;
  localparam logic [DEG_W-1:0] DEG_MAX = 14'h3FFF;

  localparam logic [1:0] ACT_ADD   = 2'd0;
  localparam logic [1:0] ACT_BUILD = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;
  localparam logic [1:0] ACT_CHECK = 2'd3;

  localparam logic [1:0] ST_OK   = 2'd0;
  localparam logic [1:0] ST_FULL = 2'd1;
  localparam logic [1:0] ST_BAD  = 2'd2;

  typedef enum logic [5:0] {
    S_CLR, S_IDLE, S_DISP, S_OUT,
    S_ADD_WA, S_ADD_WB,
    S_RD, S_CK_A, S_CK_B, S_CK_R, S_CK_C,
    S_B_INIT, S_B_MAXR, S_B_MAXU, S_B_ACLR,
    S_B_E1R, S_B_E1D, S_B_E1A, S_B_E1BR, S_B_E1BW, S_B_PFR, S_B_PFW,
    S_B_E2R, S_B_E2D, S_B_E2A, S_B_E2BR, S_B_E2BW,
    S_R_START, S_S_BCLR, S_S_K1, S_S_K2, S_S_K3, S_S_K4,
    S_S_P1, S_S_P2, S_S_X1, S_S_X2, S_S_X3, S_S_C1, S_S_C2,
    S_M_CLR, S_M_V1, S_M_V2, S_M_V3, S_M_V4, S_M_V5, S_M_V6, S_M_N1, S_M_N2
  } isi_state_t;

  function automatic logic [DEG_W-1:0] deg_sat_add(input logic [DEG_W-1:0] d,
                                                   input logic [1:0] inc);
    logic [DEG_W:0] s;
    s = {1'b0, d} + {{(DEG_W-1){1'b0}}, inc};
    return (s > {1'b0, DEG_MAX}) ? DEG_MAX : s[DEG_W-1:0];
  endfunction

endpackage

[rtl/core/isi_ram.sv]
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
module isi_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end
endmodule

[rtl/core/independent_set_signature_index_top.sv]
// Top level of the independent-set signature index: sequencer and stores.
`timescale 1ns / 1ps
// One item at a time; in_stall is low only while idle. After reset a clearing
// pass zeroes degrees, signatures and counts. A pair check walks the stored
// edges and stops at the first matching edge. A build walks the stores
// through one sequencer with one access per memory per cycle: a setup pass,
// then one sort and selection pass per round, where the sort keys run up to
// kmax, the largest degree in rounds 0 and 1 and the round number after that.
module independent_set_signature_index_top
  import isi_pkg::*;
#(
  parameter int NODES      = 1024,
  parameter int EDGE_SLOTS = 8192,
  parameter int ROUNDS     = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        in_action,
  input  logic [VERT_W-1:0] in_vertex_a,
  input  logic [VERT_W-1:0] in_vertex_b,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [SIG_W-1:0]  out_signature,
  output logic [CNT_W-1:0]  out_selection_count,
  output logic [1:0]        out_pair_code,
  output logic [1:0]        out_status,
  input  logic              cfg_wr_en,
  input  logic [CFG_W-1:0]  cfg_wr_data
);
  localparam int NA  = $clog2(NODES);
  localparam int LW  = $clog2(NODES + 1);
  localparam int EA  = (EDGE_SLOTS > 1) ? $clog2(EDGE_SLOTS) : 1;
  localparam int FW  = $clog2(EDGE_SLOTS + 1);
  localparam int AL  = $clog2(2 * EDGE_SLOTS);
  localparam int AV  = $clog2(2 * EDGE_SLOTS + 1);
  localparam int RCW = $clog2(ROUNDS + 1);
  localparam int BKT = 1 << DEG_W;

  // memory ports
  logic e_we;  logic [EA-1:0] e_wa, e_ra;  logic [EDGE_W-1:0] e_wd, e_rd;
  logic d_we;  logic [NA-1:0] d_wa, d_ra;  logic [DEG_W-1:0]  d_wd, d_rd;
  logic s_we;  logic [NA-1:0] s_wa, s_ra;  logic [SIG_W-1:0]  s_wd, s_rd;
  logic c_we;  logic [NA-1:0] c_wa, c_ra;  logic [CNT_W-1:0]  c_wd, c_rd;
  logic m_we;  logic [NA-1:0] m_wa, m_ra;  logic [0:0]        m_wd, m_rd;
  logic o_we;  logic [NA-1:0] o_wa, o_ra;  logic [VERT_W-1:0] o_wd, o_rd;
  logic t_we;  logic [NA-1:0] t_wa, t_ra;  logic [VERT_W-1:0] t_wd, t_rd;
  logic k_we;  logic [NA-1:0] k_wa, k_ra;  logic [DEG_W-1:0]  k_wd, k_rd;
  logic b_we;  logic [DEG_W-1:0] b_wa, b_ra; logic [LW-1:0]   b_wd, b_rd;
  logic as_we; logic [LW-1:0] as_wa, as_ra; logic [AV-1:0]    as_wd, as_rd;
  logic af_we; logic [NA-1:0] af_wa, af_ra; logic [AV-1:0]    af_wd, af_rd;
  logic al_we; logic [AL-1:0] al_wa, al_ra; logic [VERT_W-1:0] al_wd, al_rd;

  isi_ram #(.WIDTH(EDGE_W), .DEPTH(EDGE_SLOTS)) u_edge (.clk, .we(e_we), .waddr(e_wa),
    .wdata(e_wd), .raddr(e_ra), .rdata(e_rd));
  isi_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_deg (.clk, .we(d_we), .waddr(d_wa),
    .wdata(d_wd), .raddr(d_ra), .rdata(d_rd));
  isi_ram #(.WIDTH(SIG_W), .DEPTH(NODES)) u_sig (.clk, .we(s_we), .waddr(s_wa),
    .wdata(s_wd), .raddr(s_ra), .rdata(s_rd));
  isi_ram #(.WIDTH(CNT_W), .DEPTH(NODES)) u_cnt (.clk, .we(c_we), .waddr(c_wa),
    .wdata(c_wd), .raddr(c_ra), .rdata(c_rd));
  isi_ram #(.WIDTH(1), .DEPTH(NODES)) u_mark (.clk, .we(m_we), .waddr(m_wa),
    .wdata(m_wd), .raddr(m_ra), .rdata(m_rd));
  isi_ram #(.WIDTH(VERT_W), .DEPTH(NODES)) u_ord (.clk, .we(o_we), .waddr(o_wa),
    .wdata(o_wd), .raddr(o_ra), .rdata(o_rd));
  isi_ram #(.WIDTH(VERT_W), .DEPTH(NODES)) u_tmp (.clk, .we(t_we), .waddr(t_wa),
    .wdata(t_wd), .raddr(t_ra), .rdata(t_rd));
  isi_ram #(.WIDTH(DEG_W), .DEPTH(NODES)) u_key (.clk, .we(k_we), .waddr(k_wa),
    .wdata(k_wd), .raddr(k_ra), .rdata(k_rd));
  isi_ram #(.WIDTH(LW), .DEPTH(BKT)) u_bkt (.clk, .we(b_we), .waddr(b_wa),
    .wdata(b_wd), .raddr(b_ra), .rdata(b_rd));
  isi_ram #(.WIDTH(AV), .DEPTH(NODES + 1)) u_ast (.clk, .we(as_we), .waddr(as_wa),
    .wdata(as_wd), .raddr(as_ra), .rdata(as_rd));
  isi_ram #(.WIDTH(AV), .DEPTH(NODES)) u_afl (.clk, .we(af_we), .waddr(af_wa),
    .wdata(af_wd), .raddr(af_ra), .rdata(af_rd));
  isi_ram #(.WIDTH(VERT_W), .DEPTH(2 * EDGE_SLOTS)) u_alst (.clk, .we(al_we),
    .waddr(al_wa), .wdata(al_wd), .raddr(al_ra), .rdata(al_rd));

  isi_state_t st_r, st_nxt;
  logic [LW-1:0]     vi_r, vi_nxt, brun_r, brun_nxt;
  logic [FW-1:0]     ei_r, ei_nxt, fill_r, fill_nxt;
  logic [DEG_W-1:0]  ki_r, ki_nxt, key_r, key_nxt, largest_r, largest_nxt;
  logic [RCW-1:0]    round_r, round_nxt;
  logic [AV-1:0]     j_r, j_nxt, jend_r, jend_nxt, arun_r, arun_nxt;
  logic [VERT_W-1:0] v_r, v_nxt, ea_r, ea_nxt, eb_r, eb_nxt, tv_r, tv_nxt;
  logic [VERT_W-1:0] a_r, a_nxt, b_r, b_nxt;
  logic [1:0]        act_r, act_nxt;
  logic [CFG_W-1:0]  cfg_r;
  logic [SIG_W-1:0]  res_sig_r, res_sig_nxt;
  logic [CNT_W-1:0]  res_cnt_r, res_cnt_nxt;
  logic [1:0]        res_pair_r, res_pair_nxt, res_stat_r, res_stat_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [SIG_W-1:0]  out_sig_r, out_sig_nxt;
  logic [CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic [1:0]        out_pair_r, out_pair_nxt, out_stat_r, out_stat_nxt;

  logic [LW-1:0]     n_live;
  logic              a_ok, b_ok, ea_ok, eb_ok;
  logic [DEG_W-1:0]  kmax, bidx, key_sel;
  logic [AV:0]       psum;
  logic [VERT_W-1:0] e_x, e_y;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_CLR;
      vi_r        <= '0;
      fill_r      <= '0;
      largest_r   <= '0;
      cfg_r       <= CFG_W'(1024);
      out_valid_r <= 1'b0;
    end else begin
      st_r        <= st_nxt;
      vi_r        <= vi_nxt;
      fill_r      <= fill_nxt;
      largest_r   <= largest_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_wr_en) begin
        cfg_r <= cfg_wr_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    ei_r <= ei_nxt;  ki_r <= ki_nxt;  key_r <= key_nxt;  round_r <= round_nxt;
    j_r <= j_nxt;  jend_r <= jend_nxt;  arun_r <= arun_nxt;  brun_r <= brun_nxt;
    v_r <= v_nxt;  ea_r <= ea_nxt;  eb_r <= eb_nxt;  tv_r <= tv_nxt;
    a_r <= a_nxt;  b_r <= b_nxt;  act_r <= act_nxt;
    res_sig_r <= res_sig_nxt;  res_cnt_r <= res_cnt_nxt;
    res_pair_r <= res_pair_nxt;  res_stat_r <= res_stat_nxt;
    out_sig_r <= out_sig_nxt;  out_cnt_r <= out_cnt_nxt;
    out_pair_r <= out_pair_nxt;  out_stat_r <= out_stat_nxt;
  end

  assign n_live  = (32'(cfg_r) > NODES) ? LW'(NODES) : LW'(cfg_r);
  assign a_ok    = 32'(a_r) < 32'(n_live);
  assign b_ok    = 32'(b_r) < 32'(n_live);
  assign e_x     = e_rd[VERT_W-1:0];
  assign e_y     = e_rd[EDGE_W-1:VERT_W];
  assign ea_ok   = 32'(e_x) < 32'(n_live);
  assign eb_ok   = 32'(e_y) < 32'(n_live);
  assign kmax    = (32'(round_r) < 2) ? largest_r : DEG_W'(round_r);
  assign bidx    = (32'(round_r) == 1) ? kmax - ki_r : ki_r;
  assign key_sel = (32'(round_r) < 2) ? d_rd : DEG_W'(c_rd);
  assign psum    = {1'b0, arun_r} + {1'b0, as_rd};

  always_comb begin
    st_nxt = st_r;  vi_nxt = vi_r;  ei_nxt = ei_r;  ki_nxt = ki_r;  key_nxt = key_r;
    round_nxt = round_r;  j_nxt = j_r;  jend_nxt = jend_r;  arun_nxt = arun_r;
    brun_nxt = brun_r;  v_nxt = v_r;  ea_nxt = ea_r;  eb_nxt = eb_r;  tv_nxt = tv_r;
    a_nxt = a_r;  b_nxt = b_r;  act_nxt = act_r;  fill_nxt = fill_r;
    largest_nxt = largest_r;
    res_sig_nxt = res_sig_r;  res_cnt_nxt = res_cnt_r;
    res_pair_nxt = res_pair_r;  res_stat_nxt = res_stat_r;
    out_sig_nxt = out_sig_r;  out_cnt_nxt = out_cnt_r;
    out_pair_nxt = out_pair_r;  out_stat_nxt = out_stat_r;
    out_valid_nxt = out_valid_r && out_stall;

    e_we = 1'b0;  e_wa = '0;  e_wd = '0;  e_ra = '0;
    d_we = 1'b0;  d_wa = '0;  d_wd = '0;  d_ra = '0;
    s_we = 1'b0;  s_wa = '0;  s_wd = '0;  s_ra = '0;
    c_we = 1'b0;  c_wa = '0;  c_wd = '0;  c_ra = '0;
    m_we = 1'b0;  m_wa = '0;  m_wd = '0;  m_ra = '0;
    o_we = 1'b0;  o_wa = '0;  o_wd = '0;  o_ra = '0;
    t_we = 1'b0;  t_wa = '0;  t_wd = '0;  t_ra = '0;
    k_we = 1'b0;  k_wa = '0;  k_wd = '0;  k_ra = '0;
    b_we = 1'b0;  b_wa = '0;  b_wd = '0;  b_ra = '0;
    as_we = 1'b0; as_wa = '0; as_wd = '0; as_ra = '0;
    af_we = 1'b0; af_wa = '0; af_wd = '0; af_ra = '0;
    al_we = 1'b0; al_wa = '0; al_wd = '0; al_ra = '0;

    case (st_r)
      S_CLR: begin
        if (32'(vi_r) == NODES) begin
          st_nxt = S_IDLE;
        end else begin
          d_we = 1'b1;  d_wa = NA'(vi_r);
          s_we = 1'b1;  s_wa = NA'(vi_r);
          c_we = 1'b1;  c_wa = NA'(vi_r);
          vi_nxt = vi_r + LW'(1);
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          act_nxt = in_action;  a_nxt = in_vertex_a;  b_nxt = in_vertex_b;
          res_sig_nxt = '0;  res_cnt_nxt = '0;  res_pair_nxt = '0;
          res_stat_nxt = ST_OK;
          st_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (act_r == ACT_BUILD) begin
          vi_nxt = '0;
          st_nxt = S_B_INIT;
        end else if (!a_ok || (act_r != ACT_READ && !b_ok)) begin
          res_stat_nxt = ST_BAD;
          st_nxt = S_OUT;
        end else if (act_r == ACT_ADD) begin
          if (32'(fill_r) >= EDGE_SLOTS) begin
            res_stat_nxt = ST_FULL;
            st_nxt = S_OUT;
          end else begin
            e_we = 1'b1;  e_wa = EA'(fill_r);  e_wd = {b_r, a_r};
            fill_nxt = fill_r + FW'(1);
            d_ra = NA'(a_r);
            st_nxt = S_ADD_WA;
          end
        end else begin
          s_ra = NA'(a_r);  c_ra = NA'(a_r);
          st_nxt = (act_r == ACT_READ) ? S_RD : S_CK_A;
        end
      end
      S_ADD_WA: begin
        d_we = 1'b1;  d_wa = NA'(a_r);
        d_wd = deg_sat_add(d_rd, (a_r == b_r) ? 2'd2 : 2'd1);
        if (a_r == b_r) begin
          st_nxt = S_OUT;
        end else begin
          d_ra = NA'(b_r);
          st_nxt = S_ADD_WB;
        end
      end
      S_ADD_WB: begin
        d_we = 1'b1;  d_wa = NA'(b_r);  d_wd = deg_sat_add(d_rd, 2'd1);
        st_nxt = S_OUT;
      end
      S_RD: begin
        res_sig_nxt = s_rd;  res_cnt_nxt = c_rd;
        st_nxt = S_OUT;
      end
      S_CK_A: begin
        res_sig_nxt = s_rd;  res_cnt_nxt = c_rd;
        s_ra = NA'(b_r);
        st_nxt = S_CK_B;
      end
      S_CK_B: begin
        res_pair_nxt[1] = |(res_sig_r & s_rd);
        ei_nxt = '0;
        st_nxt = S_CK_R;
      end
      S_CK_R: begin
        if (ei_r == fill_r) begin
          st_nxt = S_OUT;
        end else begin
          e_ra = EA'(ei_r);
          st_nxt = S_CK_C;
        end
      end
      S_CK_C: begin
        if ((e_x == a_r && e_y == b_r) || (e_x == b_r && e_y == a_r)) begin
          res_pair_nxt[0] = 1'b1;
          st_nxt = S_OUT;
        end else begin
          ei_nxt = ei_r + FW'(1);
          st_nxt = S_CK_R;
        end
      end
      S_OUT: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          out_sig_nxt = res_sig_r;  out_cnt_nxt = res_cnt_r;
          out_pair_nxt = res_pair_r;  out_stat_nxt = res_stat_r;
          st_nxt = S_IDLE;
        end
      end
      // build setup: clear per-vertex results and reset the order, find largest degree, make CSR
      S_B_INIT: begin
        if (32'(vi_r) == NODES) begin
          vi_nxt = '0;  largest_nxt = '0;
          st_nxt = S_B_MAXR;
        end else begin
          s_we = 1'b1;  s_wa = NA'(vi_r);
          c_we = 1'b1;  c_wa = NA'(vi_r);
          o_we = 1'b1;  o_wa = NA'(vi_r);  o_wd = VERT_W'(vi_r);
          vi_nxt = vi_r + LW'(1);
        end
      end
      S_B_MAXR: begin
        if (vi_r == n_live) begin
          vi_nxt = '0;
          st_nxt = S_B_ACLR;
        end else begin
          d_ra = NA'(vi_r);
          st_nxt = S_B_MAXU;
        end
      end
      S_B_MAXU: begin
        if (d_rd > largest_r) begin
          largest_nxt = d_rd;
        end
        vi_nxt = vi_r + LW'(1);
        st_nxt = S_B_MAXR;
      end
      S_B_ACLR: begin
        as_we = 1'b1;  as_wa = vi_r;
        if (vi_r == n_live) begin
          ei_nxt = '0;
          st_nxt = S_B_E1R;
        end else begin
          vi_nxt = vi_r + LW'(1);
        end
      end
      S_B_E1R: begin
        if (ei_r == fill_r) begin
          vi_nxt = '0;  arun_nxt = '0;
          st_nxt = S_B_PFR;
        end else begin
          e_ra = EA'(ei_r);
          st_nxt = S_B_E1D;
        end
      end
      S_B_E1D: begin
        ea_nxt = e_x;  eb_nxt = e_y;
        if (ea_ok && eb_ok) begin
          as_ra = LW'(32'(e_x) + 1);
          st_nxt = S_B_E1A;
        end else begin
          ei_nxt = ei_r + FW'(1);
          st_nxt = S_B_E1R;
        end
      end
      S_B_E1A: begin
        as_we = 1'b1;  as_wa = LW'(32'(ea_r) + 1);  as_wd = as_rd + AV'(1);
        st_nxt = S_B_E1BR;
      end
      S_B_E1BR: begin
        as_ra = LW'(32'(eb_r) + 1);
        st_nxt = S_B_E1BW;
      end
      S_B_E1BW: begin
        as_we = 1'b1;  as_wa = LW'(32'(eb_r) + 1);  as_wd = as_rd + AV'(1);
        ei_nxt = ei_r + FW'(1);
        st_nxt = S_B_E1R;
      end
      S_B_PFR: begin
        as_ra = vi_r;
        st_nxt = S_B_PFW;
      end
      S_B_PFW: begin
        // running sum turns counts into start offsets
        as_we = 1'b1;  as_wa = vi_r;  as_wd = psum[AV-1:0];
        arun_nxt = psum[AV-1:0];
        if (vi_r != n_live) begin
          af_we = 1'b1;  af_wa = NA'(vi_r);  af_wd = psum[AV-1:0];
          vi_nxt = vi_r + LW'(1);
          st_nxt = S_B_PFR;
        end else begin
          ei_nxt = '0;
          st_nxt = S_B_E2R;
        end
      end
      S_B_E2R: begin
        if (ei_r == fill_r) begin
          round_nxt = '0;
          st_nxt = S_R_START;
        end else begin
          e_ra = EA'(ei_r);
          st_nxt = S_B_E2D;
        end
      end
      S_B_E2D: begin
        ea_nxt = e_x;  eb_nxt = e_y;
        if (ea_ok && eb_ok) begin
          af_ra = NA'(e_x);
          st_nxt = S_B_E2A;
        end else begin
          ei_nxt = ei_r + FW'(1);
          st_nxt = S_B_E2R;
        end
      end
      S_B_E2A: begin
        al_we = 1'b1;  al_wa = AL'(af_rd);  al_wd = eb_r;
        af_we = 1'b1;  af_wa = NA'(ea_r);  af_wd = af_rd + AV'(1);
        st_nxt = S_B_E2BR;
      end
      S_B_E2BR: begin
        af_ra = NA'(eb_r);
        st_nxt = S_B_E2BW;
      end
      S_B_E2BW: begin
        al_we = 1'b1;  al_wa = AL'(af_rd);  al_wd = ea_r;
        af_we = 1'b1;  af_wa = NA'(eb_r);  af_wd = af_rd + AV'(1);
        ei_nxt = ei_r + FW'(1);
        st_nxt = S_B_E2R;
      end
      // one round: counting sort of the order, then greedy selection
      S_R_START: begin
        if (32'(round_r) == ROUNDS) begin
          st_nxt = S_OUT;
        end else begin
          ki_nxt = '0;
          st_nxt = S_S_BCLR;
        end
      end
      S_S_BCLR: begin
        b_we = 1'b1;  b_wa = ki_r;
        if (ki_r == kmax) begin
          vi_nxt = '0;
          st_nxt = S_S_K1;
        end else begin
          ki_nxt = ki_r + DEG_W'(1);
        end
      end
      S_S_K1: begin
        if (vi_r == n_live) begin
          ki_nxt = '0;  brun_nxt = '0;
          st_nxt = S_S_P1;
        end else begin
          o_ra = NA'(vi_r);
          st_nxt = S_S_K2;
        end
      end
      S_S_K2: begin
        d_ra = NA'(o_rd);  c_ra = NA'(o_rd);
        st_nxt = S_S_K3;
      end
      S_S_K3: begin
        key_nxt = key_sel;
        k_we = 1'b1;  k_wa = NA'(vi_r);  k_wd = key_sel;
        b_ra = key_sel;
        st_nxt = S_S_K4;
      end
      S_S_K4: begin
        b_we = 1'b1;  b_wa = key_r;  b_wd = b_rd + LW'(1);
        vi_nxt = vi_r + LW'(1);
        st_nxt = S_S_K1;
      end
      S_S_P1: begin
        b_ra = bidx;
        st_nxt = S_S_P2;
      end
      S_S_P2: begin
        b_we = 1'b1;  b_wa = bidx;  b_wd = brun_r;
        brun_nxt = brun_r + b_rd;
        if (ki_r == kmax) begin
          vi_nxt = '0;
          st_nxt = S_S_X1;
        end else begin
          ki_nxt = ki_r + DEG_W'(1);
          st_nxt = S_S_P1;
        end
      end
      S_S_X1: begin
        if (vi_r == n_live) begin
          vi_nxt = '0;
          st_nxt = S_S_C1;
        end else begin
          k_ra = NA'(vi_r);  o_ra = NA'(vi_r);
          st_nxt = S_S_X2;
        end
      end
      S_S_X2: begin
        key_nxt = k_rd;  tv_nxt = o_rd;
        b_ra = k_rd;
        st_nxt = S_S_X3;
      end
      S_S_X3: begin
        t_we = 1'b1;  t_wa = NA'(b_rd);  t_wd = tv_r;
        b_we = 1'b1;  b_wa = key_r;  b_wd = b_rd + LW'(1);
        vi_nxt = vi_r + LW'(1);
        st_nxt = S_S_X1;
      end
      S_S_C1: begin
        if (vi_r == n_live) begin
          vi_nxt = '0;
          st_nxt = S_M_CLR;
        end else begin
          t_ra = NA'(vi_r);
          st_nxt = S_S_C2;
        end
      end
      S_S_C2: begin
        o_we = 1'b1;  o_wa = NA'(vi_r);  o_wd = t_rd;
        vi_nxt = vi_r + LW'(1);
        st_nxt = S_S_C1;
      end
      S_M_CLR: begin
        if (vi_r == n_live) begin
          vi_nxt = '0;
          st_nxt = S_M_V1;
        end else begin
          m_we = 1'b1;  m_wa = NA'(vi_r);
          vi_nxt = vi_r + LW'(1);
        end
      end
      S_M_V1: begin
        if (vi_r == n_live) begin
          round_nxt = round_r + RCW'(1);
          st_nxt = S_R_START;
        end else begin
          o_ra = NA'(vi_r);
          st_nxt = S_M_V2;
        end
      end
      S_M_V2: begin
        v_nxt = o_rd;
        m_ra = NA'(o_rd);
        st_nxt = S_M_V3;
      end
      S_M_V3: begin
        if (m_rd[0]) begin
          vi_nxt = vi_r + LW'(1);
          st_nxt = S_M_V1;
        end else begin
          m_we = 1'b1;  m_wa = NA'(v_r);  m_wd = 1'b1;
          s_ra = NA'(v_r);  c_ra = NA'(v_r);
          st_nxt = S_M_V4;
        end
      end
      S_M_V4: begin
        s_we = 1'b1;  s_wa = NA'(v_r);  s_wd = s_rd | (SIG_W'(1) << round_r);
        c_we = 1'b1;  c_wa = NA'(v_r);  c_wd = c_rd + CNT_W'(1);
        as_ra = LW'(v_r);
        st_nxt = S_M_V5;
      end
      S_M_V5: begin
        j_nxt = as_rd;
        as_ra = LW'(32'(v_r) + 1);
        st_nxt = S_M_V6;
      end
      S_M_V6: begin
        jend_nxt = as_rd;
        st_nxt = S_M_N1;
      end
      S_M_N1: begin
        if (j_r == jend_r) begin
          vi_nxt = vi_r + LW'(1);
          st_nxt = S_M_V1;
        end else begin
          al_ra = AL'(j_r);
          st_nxt = S_M_N2;
        end
      end
      S_M_N2: begin
        // mark the neighbor; a chosen vertex is already marked
        m_we = 1'b1;  m_wa = NA'(al_rd);  m_wd = 1'b1;
        j_nxt = j_r + AV'(1);
        st_nxt = S_M_N1;
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  assign in_stall            = (st_r != S_IDLE);
  assign out_valid           = out_valid_r;
  assign out_signature       = out_sig_r;
  assign out_selection_count = out_cnt_r;
  assign out_pair_code       = out_pair_r;
  assign out_status          = out_stat_r;

`ifndef NO_ASSERTIONS
  a_out_from_seq: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(st_r == S_OUT))
    else $error("result beat raised outside the output step");
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    32'(fill_r) <= EDGE_SLOTS)
    else $error("edge fill past store size");
  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stat_r == ST_BAD |-> out_sig_r == '0 && out_cnt_r == '0
      && out_pair_r == 2'd0)
    else $error("bad-vertex beat carries data");
  a_clr_stall: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_CLR |-> in_stall && !out_valid_r)
    else $error("activity during clearing pass");
`endif
endmodule

[bench/independent_set_signature_index_top_tb.sv]
// Self-checking testbench for the independent-set signature index top level.
`timescale 1ns / 1ps
module independent_set_signature_index_top_tb;
  import isi_pkg::*;

  localparam int NODES      = 1024;
  localparam int EDGE_SLOTS = 8192;
  localparam int ROUNDS     = 64;
  localparam int WATCH_LIMIT = 1000000;

  typedef struct {
    logic [SIG_W-1:0] signature;
    logic [CNT_W-1:0] count;
    logic [1:0]       code;
    logic [1:0]       status;
  } answer_t;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [1:0]        in_action;
  logic [VERT_W-1:0] in_vertex_a;
  logic [VERT_W-1:0] in_vertex_b;
  logic              out_valid;
  logic              out_stall;
  logic [SIG_W-1:0]  out_signature;
  logic [CNT_W-1:0]  out_selection_count;
  logic [1:0]        out_pair_code;
  logic [1:0]        out_status;
  logic              cfg_wr_en;
  logic [CFG_W-1:0]  cfg_wr_data;

  independent_set_signature_index_top #(
    .NODES(NODES), .EDGE_SLOTS(EDGE_SLOTS), .ROUNDS(ROUNDS)
  ) dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_action(in_action),
    .in_vertex_a(in_vertex_a), .in_vertex_b(in_vertex_b),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_signature(out_signature), .out_selection_count(out_selection_count),
    .out_pair_code(out_pair_code), .out_status(out_status),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // predicted index state
  logic [CFG_W-1:0]  node_limit;
  logic [EDGE_W-1:0] edge_list[$];
  logic [DEG_W-1:0]  degree[NODES];
  logic [SIG_W-1:0]  signature[NODES];
  logic [CNT_W-1:0]  chosen[NODES];
  int                order[NODES];
  logic [1:0]        mark[NODES];
  int                neighbors[NODES][$];

  answer_t pending_answers[$];
  int      errors = 0;
  int      results_seen = 0;
  int      builds_sent, adds_sent, checks_sent, reads_sent;
  bit      quiet;
  int      ostall_left;
  int      idle_cycles;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int live_count();
    return (node_limit > NODES) ? NODES : int'(node_limit);
  endfunction

  function automatic int sort_key(int v, int k);
    return (k < 2) ? int'(degree[v]) : int'(chosen[v]);
  endfunction

  function automatic void build_signatures();
    int n, i, j, k, v, kv;
    n = live_count();
    for (i = 0; i < NODES; i++) begin
      signature[i] = '0;
      chosen[i] = '0;
      mark[i] = 2'd0;
      order[i] = i;
      neighbors[i].delete();
    end
    foreach (edge_list[e]) begin
      int a, b;
      a = int'(edge_list[e][9:0]);
      b = int'(edge_list[e][19:10]);
      if (a < n && b < n) begin
        neighbors[a].insert(neighbors[a].size(), b);
        neighbors[b].insert(neighbors[b].size(), a);
      end
    end
    for (k = 0; k < ROUNDS; k++) begin
      // stable insertion sort of the current order
      for (i = 1; i < n; i++) begin
        v = order[i];
        kv = sort_key(v, k);
        j = i;
        while (j > 0 && ((k == 1) ? (sort_key(order[j-1], k) < kv)
                                  : (sort_key(order[j-1], k) > kv))) begin
          order[j] = order[j-1];
          j--;
        end
        order[j] = v;
      end
      for (i = 0; i < n; i++) mark[i] = 2'd0;
      for (i = 0; i < n; i++) begin
        v = order[i];
        if (mark[v] == 2'd0) begin
          mark[v] = 2'd2;
          signature[v][k] = 1'b1;
          chosen[v] = chosen[v] + 1'b1;
          foreach (neighbors[v][m])
            if (mark[neighbors[v][m]] == 2'd0) mark[neighbors[v][m]] = 2'd1;
        end
      end
    end
  endfunction

  function automatic bit joined(int a, int b);
    foreach (edge_list[e]) begin
      int x, y;
      x = int'(edge_list[e][9:0]);
      y = int'(edge_list[e][19:10]);
      if ((x == a && y == b) || (x == b && y == a)) return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic logic [DEG_W-1:0] bump(logic [DEG_W-1:0] d, int inc);
    int s;
    s = int'(d) + inc;
    return (s > int'(DEG_MAX)) ? DEG_MAX : s[DEG_W-1:0];
  endfunction

  function automatic answer_t predict_answer(logic [1:0] act, int a, int b);
    answer_t r;
    int n;
    r = '{signature: '0, count: '0, code: 2'd0, status: ST_OK};
    n = live_count();
    if (act == ACT_BUILD) begin
      build_signatures();
      return r;
    end
    if (a >= n || (act != ACT_READ && b >= n)) begin
      r.status = ST_BAD;
      return r;
    end
    if (act == ACT_ADD) begin
      if (edge_list.size() >= EDGE_SLOTS) begin
        r.status = ST_FULL;
        return r;
      end
      edge_list.insert(edge_list.size(), {b[9:0], a[9:0]});
      if (a == b) degree[a] = bump(degree[a], 2);
      else begin
        degree[a] = bump(degree[a], 1);
        degree[b] = bump(degree[b], 1);
      end
      return r;
    end
    r.signature = signature[a];
    r.count = chosen[a];
    if (act == ACT_CHECK)
      r.code = {|(signature[a] & signature[b]), joined(a, b)};
    return r;
  endfunction

  // offer one beat and hold it until accepted; valid stays high afterwards
  task automatic send_item(logic [1:0] act, int a, int b);
    int gap;
    gap = quiet ? 0 : (($urandom_range(0, 4) == 0) ? $urandom_range(1, 16) : 0);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_action   <= act;
    in_vertex_a <= a[9:0];
    in_vertex_b <= b[9:0];
    do @(posedge clk); while (in_stall);
    pending_answers.insert(pending_answers.size(), predict_answer(act, a, b));
    case (act)
      ACT_ADD:   adds_sent++;
      ACT_BUILD: builds_sent++;
      ACT_READ:  reads_sent++;
      default:   checks_sent++;
    endcase
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_answers.size() != 0) @(posedge clk);
  endtask

  task automatic set_nodes(int value);
    drain();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value[CFG_W-1:0];
    @(posedge clk);
    node_limit = value[CFG_W-1:0];
    cfg_wr_en <= 1'b0;
  endtask

  function automatic int pick_vertex(int n);
    if (n == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, NODES - 1);
    return $urandom_range(0, n - 1);
  endfunction

  task automatic test_directed();
    set_nodes(0);
    send_item(ACT_READ, 0, 0);
    send_item(ACT_ADD, 0, 0);
    send_item(ACT_BUILD, 0, 0);
    set_nodes(2047);
    send_item(ACT_READ, 1023, 0);
    send_item(ACT_ADD, 1023, 1022);
    send_item(ACT_CHECK, 1022, 1023);
    set_nodes(1);
    send_item(ACT_READ, 0, 1023);
    send_item(ACT_ADD, 0, 1);
    send_item(ACT_ADD, 0, 0);
    send_item(ACT_BUILD, 0, 0);
    send_item(ACT_CHECK, 0, 0);
    set_nodes(8);
    send_item(ACT_ADD, 1, 2);
    send_item(ACT_ADD, 1, 2);
    send_item(ACT_ADD, 2, 3);
    send_item(ACT_ADD, 7, 7);
    send_item(ACT_ADD, 8, 1);
    send_item(ACT_BUILD, 0, 0);
    send_item(ACT_READ, 2, 0);
    send_item(ACT_CHECK, 1, 2);
    send_item(ACT_CHECK, 1, 3);
    send_item(ACT_CHECK, 7, 7);
    send_item(ACT_CHECK, 0, 8);
  endtask

  task automatic test_random(int phases, int per_phase);
    int sizes[7] = '{1, 2, 5, 9, 16, 24, 1024};
    int n, pick;
    for (int p = 0; p < phases; p++) begin
      n = sizes[$urandom_range(0, 6)];
      if (p == phases - 1) quiet = 1'b1;
      set_nodes(n);
      for (int i = 0; i < per_phase; i++) begin
        pick = $urandom_range(0, 31);
        if (pick == 0 && n <= 64) send_item(ACT_BUILD, $urandom_range(0, 1023),
                                            $urandom_range(0, 1023));
        else if (pick < 14) send_item(ACT_ADD, pick_vertex(n), pick_vertex(n));
        else if (pick < 23) send_item(ACT_READ, pick_vertex(n), $urandom_range(0, 1023));
        else send_item(ACT_CHECK, pick_vertex(n), pick_vertex(n));
      end
    end
  endtask

  task automatic test_wide_build();
    set_nodes(128);
    for (int i = 0; i < 40; i++)
      send_item(ACT_ADD, $urandom_range(0, 127), $urandom_range(0, 127));
    send_item(ACT_BUILD, 0, 0);
    for (int i = 0; i < 10; i++)
      send_item(ACT_CHECK, $urandom_range(0, 127), $urandom_range(0, 127));
  endtask

  always @(posedge clk) begin
    if (!rst_n || quiet) begin
      out_stall <= 1'b0;
      ostall_left <= 0;
    end else if (ostall_left > 0) begin
      ostall_left <= ostall_left - 1;
      out_stall <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      ostall_left <= $urandom_range(0, 15);
      out_stall <= 1'b1;
    end else begin
      out_stall <= 1'b0;
    end
  end

  always @(posedge clk) begin
    answer_t exp_r;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_answers.size() == 0) begin
        $display("%0t: result beat with nothing expected, status %0d", $time, out_status);
        errors++;
      end else begin
        exp_r = pending_answers.pop_front();
        if (out_signature !== exp_r.signature) begin
          $display("%0t: signature expected %h actual %h", $time, exp_r.signature,
                   out_signature);
          errors++;
        end
        if (out_selection_count !== exp_r.count) begin
          $display("%0t: selection_count expected %0d actual %0d", $time, exp_r.count,
                   out_selection_count);
          errors++;
        end
        if (out_pair_code !== exp_r.code) begin
          $display("%0t: pair_code expected %0d actual %0d", $time, exp_r.code,
                   out_pair_code);
          errors++;
        end
        if (out_status !== exp_r.status) begin
          $display("%0t: status expected %0d actual %0d", $time, exp_r.status, out_status);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCH_LIMIT) begin
      $display("watchdog expired at %0t", $time);
      $display("simulation failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_action = ACT_ADD;
    in_vertex_a = '0;
    in_vertex_b = '0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    quiet = 1'b0;
    builds_sent = 0;
    adds_sent = 0;
    checks_sent = 0;
    reads_sent = 0;
    node_limit = 11'd1024;
    for (int i = 0; i < NODES; i++) begin
      degree[i] = '0;
      signature[i] = '0;
      chosen[i] = '0;
      order[i] = i;
    end
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    test_directed();
    test_random(10, 52);
    test_wide_build();

    drain();
    repeat (100) @(posedge clk);
    if (pending_answers.size() != 0) begin
      $display("%0d expected results never arrived", pending_answers.size());
      errors++;
    end
    $display("covered %0d adds, %0d builds, %0d reads, %0d pair checks, %0d results",
             adds_sent, builds_sent, reads_sent, checks_sent, results_seen);
    $display("node counts from 0 to 2047, bad vertices, self loops, duplicate edges");
    if (errors == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[independent_set_signature_index_top.f]
rtl/core/isi_pkg.sv
rtl/core/isi_ram.sv
rtl/core/independent_set_signature_index_top.sv
bench/independent_set_signature_index_top_tb.sv
